### rtl/core/hnps_pkg.sv
// Shared constants for the hash noise point scatter block.
package hnps_pkg;

  // Lattice index width, used for the point index port
  localparam int INDEX_BITS = 16;

  // Edges from an accepted start to the result strobe
  localparam int LAT = 7;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;

  // Reset values of the bounds, Q16.16
  localparam logic [31:0] BOUND_LO_RST = 32'h0000_0000;
  localparam logic [31:0] BOUND_HI_RST = 32'h0001_0000;

  // Lattice noise hash constants
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD   = 32'd789221;
  localparam logic [31:0] HASH_OFS   = 32'd1376312589;
  localparam logic [63:0] ROUND_UP   = 64'h0000_0000_7fff_ffff;

  typedef logic [31:0] word_t;

endpackage

### rtl/core/hnps_lane.sv
// One coordinate lane: lattice noise hash followed by scaling into the bounds.
module hnps_lane import hnps_pkg::*; (
  input  logic                  clk,
  input  word_t                 lat_x,
  input  logic [INDEX_BITS-1:0] idx,
  input  word_t                 lo,
  input  word_t                 hi,
  output word_t                 coord
);

  word_t       ly;
  word_t       n0;
  word_t       n1_nxt, n1_r;
  word_t       sq2_nxt, sq2_r, n2_r;
  word_t       t3_nxt, t3_r, n3_r;
  word_t       u4_nxt, u4_r;
  logic [30:0] m5_nxt, m5_r;
  logic [62:0] mag6_nxt, mag6_r;
  logic [63:0] mag_up;
  word_t       coord_nxt, coord_r;
  logic [32:0] diff, diff_neg;
  word_t       absd_nxt, absd_r;
  logic        neg_nxt, neg_r;

  // Offset add and 31-bit mask of the hash
  function automatic logic [30:0] u4_nxt_trunc(input word_t u);
    word_t s;
    s = u + HASH_OFS;
    return s[30:0];
  endfunction

  // Stage 1: n = x + 57*y, then n ^= n << 13
  always_comb begin
    ly     = {{(32-INDEX_BITS){1'b0}}, idx};
    n0     = lat_x + (ly << 6) - (ly << 3) + ly;
    n1_nxt = n0 ^ (n0 << 13);
  end

  // Stage 2: n*n, stage 3: *15731 + 789221, stage 4: n*(...), stage 5: + offset, mask
  assign sq2_nxt = n1_r * n1_r;
  assign t3_nxt  = sq2_r * HASH_MUL + HASH_ADD;
  assign u4_nxt  = n3_r * t3_r;
  assign m5_nxt  = u4_nxt_trunc(u4_r);

  // Bound span, refreshed from configuration every cycle
  always_comb begin
    diff     = {hi[31], hi} - {lo[31], lo};
    diff_neg = 33'd0 - diff;
    neg_nxt  = diff[32];
    absd_nxt = diff[32] ? diff_neg[31:0] : diff[31:0];
  end

  // Stage 6: |span| * m
  assign mag6_nxt = 63'(absd_r) * 63'(m5_r);

  // Stage 7: hi - floor(span * m / 2^31)
  always_comb begin
    mag_up    = {1'b0, mag6_r} + ROUND_UP;
    coord_nxt = neg_r ? (hi + mag_up[62:31]) : (hi - mag6_r[62:31]);
  end

  always_ff @(posedge clk) begin
    n1_r    <= n1_nxt;
    n2_r    <= n1_r;
    sq2_r   <= sq2_nxt;
    n3_r    <= n2_r;
    t3_r    <= t3_nxt;
    u4_r    <= u4_nxt;
    m5_r    <= m5_nxt;
    mag6_r  <= mag6_nxt;
    coord_r <= coord_nxt;
    absd_r  <= absd_nxt;
    neg_r   <= neg_nxt;
  end

  assign coord = coord_r;

endmodule

### rtl/core/hash_noise_point_scatter.sv
// Top level: scattered 2D point generator built on a lattice noise hash.
// out_valid strobes when an accepted start leaves the pipeline.
// Throughput: one point per cycle; busy is never raised, the seven-stage
// hash and scale pipeline (three 32x32 multiplies, one 32x31) sets latency.
// Reset (rst_n low, synchronous) empties the pipeline and loads seed 0,
// bounds [0, 1.0] for both axes; results cannot be stalled by the receiver.
module hash_noise_point_scatter import hnps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] in_point_index,
  input  logic                  in_last_point,
  output logic                  out_valid,
  output logic signed [31:0]    out_coord_x,
  output logic signed [31:0]    out_coord_y,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  word_t          seed_r, min_x_r, min_y_r, max_x_r, max_y_r;
  word_t          seed_y;
  logic           accept;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [LAT-1:0] last_r, last_nxt;
  word_t          coord_x, coord_y;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Configuration register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= 32'd0;
      min_x_r <= BOUND_LO_RST;
      min_y_r <= BOUND_LO_RST;
      max_x_r <= BOUND_HI_RST;
      max_y_r <= BOUND_HI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEED:  seed_r  <= cfg_data;
        REG_MIN_X: min_x_r <= cfg_data;
        REG_MIN_Y: min_y_r <= cfg_data;
        REG_MAX_X: max_x_r <= cfg_data;
        REG_MAX_Y: max_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // y axis hashes the next lattice column
  assign seed_y = seed_r + 32'd1;

  hnps_lane u_lane_x (
    .clk   (clk),
    .lat_x (seed_r),
    .idx   (in_point_index),
    .lo    (min_x_r),
    .hi    (max_x_r),
    .coord (coord_x)
  );

  hnps_lane u_lane_y (
    .clk   (clk),
    .lat_x (seed_y),
    .idx   (in_point_index),
    .lo    (min_y_r),
    .hi    (max_y_r),
    .coord (coord_y)
  );

  // Valid and last markers travel beside the lane stages
  assign vld_nxt  = {vld_r[LAT-2:0], accept};
  assign last_nxt = {last_r[LAT-2:0], in_last_point};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_last    = last_r[LAT-1];
  assign out_coord_x = coord_x;
  assign out_coord_y = coord_y;

endmodule

### bench/tb_hash_noise_point_scatter.sv
// Testbench for hash_noise_point_scatter: random and corner points against a predictor.
`timescale 1ns / 1ps

module tb_hash_noise_point_scatter;
  import hnps_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_POINTS = 200;
  localparam int CYCLE_LIMIT  = 200000;
  // Register indexes past the map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam int SPARE_REGS = 3;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               last;
  } point_t;

  // Mirror of the bound/seed registers plus the queue of predicted points
  class point_tracker;
    word_t  seed, min_x, min_y, max_x, max_y;
    point_t expected_points[$];
    int     errors;

    function new();
      seed   = '0;
      min_x  = BOUND_LO_RST;
      min_y  = BOUND_LO_RST;
      max_x  = BOUND_HI_RST;
      max_y  = BOUND_HI_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
      case (idx)
        REG_SEED:  seed  = data;
        REG_MIN_X: min_x = data;
        REG_MIN_Y: min_y = data;
        REG_MAX_X: max_x = data;
        REG_MAX_Y: max_y = data;
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    // Integer lattice noise hash, 32-bit wrapping, 31-bit result
    function word_t lattice_hash(word_t lx, word_t ly);
      word_t n;
      n = lx + ly * 32'd57;
      n = n ^ (n << 13);
      return (n * (n * n * HASH_MUL + HASH_ADD) + HASH_OFS) & 32'h7fff_ffff;
    endfunction

    // max - floor((max - min) * m / 2^31), span taken at full signed width
    function word_t fit_to_bounds(word_t lo, word_t hi, word_t m);
      longint      span;
      logic [63:0] mag;
      longint      step;
      span = longint'($signed(hi)) - longint'($signed(lo));
      if (span >= 0) begin
        mag  = 64'(span) * {32'd0, m};
        step = longint'(mag >> 31);
      end else begin
        mag  = 64'(-span) * {32'd0, m};
        step = -longint'((mag + ROUND_UP) >> 31);
      end
      return word_t'(longint'($signed(hi)) - step);
    endfunction

    function void note_point(logic [INDEX_BITS-1:0] idx, logic last);
      point_t p;
      p.coord_x = fit_to_bounds(min_x, max_x, lattice_hash(seed, word_t'(idx)));
      p.coord_y = fit_to_bounds(min_y, max_y, lattice_hash(seed + 32'd1, word_t'(idx)));
      p.last    = last;
      expected_points.insert(expected_points.size(), p);
    endfunction

    function void check_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
      point_t p;
      if (expected_points.size() == 0) begin
        $error("unexpected point: coord_x %0d coord_y %0d last %0d", x, y, last);
        errors++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.coord_x) begin
        $error("coord_x mismatch: expected %0d, got %0d", p.coord_x, x);
        errors++;
      end
      if (y !== p.coord_y) begin
        $error("coord_y mismatch: expected %0d, got %0d", p.coord_y, y);
        errors++;
      end
      if (last !== p.last) begin
        $error("last mismatch: expected %0d, got %0d", p.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [INDEX_BITS-1:0] in_point_index;
  logic                  in_last_point;
  logic                  out_valid;
  logic signed [31:0]    out_coord_x;
  logic signed [31:0]    out_coord_y;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;

  point_tracker tracker = new();
  int cycles = 0;

  hash_noise_point_scatter DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_index (in_point_index),
    .in_last_point  (in_last_point),
    .out_valid      (out_valid),
    .out_coord_x    (out_coord_x),
    .out_coord_y    (out_coord_y),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_hash_noise_point_scatter: done, errors");
      $finish;
    end
  end

  // Check result strobes, then record accepted input transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) tracker.check_point(out_coord_x, out_coord_y, out_last);
      if (start && !busy) tracker.note_point(in_point_index, in_last_point);
    end
  end

  task automatic send_point(input logic [INDEX_BITS-1:0] idx, input logic last);
    @(negedge clk);
    start          <= 1'b1;
    in_point_index <= idx;
    in_last_point  <= last;
    do @(posedge clk); while (busy);
  endtask

  // Random idle cycles ahead of the next point
  task automatic hold_off(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stop sending and wait until every predicted point has come out
  task automatic drain_points();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input word_t sd, input word_t mnx, input word_t mny,
                               input word_t mxx, input word_t mxy);
    write_reg(REG_SEED, sd);
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MAX_Y, mxy);
  endtask

  // Register values biased toward the signed extremes and small Q16.16 spans
  function automatic word_t pick_word();
    word_t r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_index();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return INDEX_BITS'($urandom);
    endcase
  endfunction

  task automatic configure_phase(input int p);
    case (p)
      0: ;  // reset values stand
      1: begin
        // full positive span on x, equal bounds on y, seed + 1 wraps to the sign bit
        apply_setting(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678,
                      32'h7fff_ffff, 32'h1234_5678);
        for (int k = 0; k < SPARE_REGS; k++)
          write_reg(REG_SPARE_FIRST + CFG_IDX_W'(k), $urandom);
      end
      // swapped bounds, full negative span on x; seed + 1 wraps to zero
      2: apply_setting(32'hffff_ffff, 32'h7fff_ffff, 32'h0003_0000,
                       32'h8000_0000, 32'hfffe_0000);
      3: apply_setting(32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                       32'h8000_0000, 32'h7fff_ffff);
      default: apply_setting(pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
    endcase
  endtask

  initial begin
    int pct;
    start          = 1'b0;
    in_point_index = '0;
    in_last_point  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SEED;
    cfg_data       = '0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner indexes under the reset setting
    send_point(16'h0000, 1'b0);
    send_point(16'hffff, 1'b1);
    send_point(16'h0001, 1'b0);
    send_point(16'h8000, 1'b1);
    send_point(16'h7fff, 1'b0);
    send_point(16'h5555, 1'b0);
    send_point(16'haaaa, 1'b1);
    send_point(16'h00ff, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      pct = (p < 4) ? 32 : (p < 7) ? 66 : 0;
      if (p != 0) drain_points();
      configure_phase(p);
      if (p >= 1 && p <= 3) begin
        send_point(16'h0000, 1'b0);
        send_point(16'hffff, 1'b1);
      end
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if ((p == 0 && n == PHASE_POINTS / 2) || $urandom_range(0, 149) == 0)
          drain_points();
        hold_off(pct);
        send_point(pick_index(), $urandom_range(0, 7) == 0);
      end
    end

    drain_points();
    if (tracker.errors == 0) begin
      $display("tb_hash_noise_point_scatter: done, clean");
    end else begin
      $display("tb_hash_noise_point_scatter: done, errors");
    end
    $finish;
  end

endmodule
